>>> design/distorted_pinhole_projection_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the distorted pinhole projection block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DISTORTED_PINHOLE_PROJECTION_TOP_MACROS_SVH
`define DISTORTED_PINHOLE_PROJECTION_TOP_MACROS_SVH
`ifndef SYNTHESIS
// check sampled on clk, ignored while rst is high
`define DPP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dpp assertion failed");
// check sampled on clk, active during reset as well
`define DPP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("dpp assertion failed");
`else
`define DPP_ASSERT(label, clk, rst, prop)
`define DPP_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> design/dpp_pkg.sv
// ----------------------------------------------------------------------------
// dpp_pkg
// Types, register codes and fixed-point widths of the projection block.
// ----------------------------------------------------------------------------
package dpp_pkg;

  localparam int CAM_SLOTS   = 2;   // camera field is one bit
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_CAM_BIT = 2;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  localparam int FRAC    = 30;
  localparam int MUL_LAT = 2;

  // Q.30 value widths, sized from the clamp of xn, yn to +-8.0
  localparam int W_Q     = 34;
  localparam int W_N     = 35;
  localparam int W_SQ    = 38;
  localparam int W_R2    = 39;
  localparam int W_T     = 40;
  localparam int W_R4    = 46;
  localparam int W_K1R2  = 40;
  localparam int W_PXY   = 39;
  localparam int W_PT    = 41;
  localparam int W_K2R4  = 47;
  localparam int W_F     = 48;
  localparam int W_TAN   = 42;
  localparam int W_XF    = 51;
  localparam int W_X1    = 51;
  localparam int W_PIX   = 54;
  localparam int W_U     = 55;

  localparam logic [W_Q-1:0] NORM_LIM = W_Q'(64'd1 << (FRAC + 3));

  typedef enum logic [1:0] {
    REG_FOCAL      = 2'd0,
    REG_CENTER     = 2'd1,
    REG_RADIAL     = 2'd2,
    REG_TANGENTIAL = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic               camera;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_beat_t;

  typedef struct packed {
    logic signed [31:0] pixel_u;
    logic signed [31:0] pixel_v;
    logic               behind_camera;
    logic               saturated;
  } pixel_beat_t;

  typedef struct packed {
    logic        [31:0] fx;
    logic        [31:0] fy;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } cam_cfg_t;

  typedef struct packed {
    logic               cam;
    logic               behind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } work_t;

  typedef struct packed {
    logic cam;
    logic behind;
    logic sat;
  } tag_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_status_t;

endpackage

>>> design/distorted_pinhole_projection_top.sv
// ----------------------------------------------------------------------------
// distorted_pinhole_projection_top
// Pinhole projection with radial-tangential lens distortion, one point a beat.
// ----------------------------------------------------------------------------
// Usage:
//  - point channel (point_valid / point_stall / point) carries one camera-frame
//    point a beat: camera index plus x, y, z in signed Q16.16.
//  - pixel channel (pixel_valid / pixel_stall / pixel) returns one beat per
//    point, in order: u, v in Q16.16, behind_camera and saturated flags.
//  - cfg_write / cfg_index / cfg_data write the 64-bit intrinsic and
//    distortion registers, four per camera; write only while idle.
//  - Throughput is one point per cycle while pixel_stall holds no waiting
//    result; the 17-stage pipelined divider (two quotient bits a stage) and
//    the split multipliers that follow it are fully pipelined.
//  - Reset zeroes the camera registers, empties the queue and pipeline;
//    there is no clearing pass, points are taken as soon as reset is released.
//  - While pixel_stall holds a waiting result, the whole back pipeline
//    freezes; the 4-entry queue keeps taking points until it fills, then
//    point_stall rises.
// ----------------------------------------------------------------------------
`include "distorted_pinhole_projection_top_macros.svh"

module distorted_pinhole_projection_top import dpp_pkg::*; #(
  parameter int NUM_CAMERAS = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  point_valid,
  output logic                  point_stall,
  input  point_beat_t           point,
  output logic                  pixel_valid,
  input  logic                  pixel_stall,
  output pixel_beat_t           pixel
);

  queue_status_t q_status;
  logic          push;
  logic          pop;
  work_t         work_in;
  work_t         work_head;
  cam_cfg_t      cfg_view [CAM_SLOTS];

  // front: register file, camera select, depth check
  dpp_front #(.NUM_CAMERAS(NUM_CAMERAS)) u_front (
    .clk, .rst,
    .cfg_write, .cfg_index, .cfg_data,
    .point_valid, .point_stall, .point,
    .q_status, .push, .work(work_in), .cfg_view
  );

  // decouples input acceptance from back-end stalls
  dpp_queue u_queue (
    .clk, .rst,
    .push, .wdata(work_in),
    .pop, .rdata(work_head),
    .status(q_status)
  );

  // back: divider, distortion math, pixel clamp, output register
  dpp_back u_back (
    .clk, .rst,
    .cfg_view, .q_status, .head(work_head), .pop,
    .pixel_valid, .pixel_stall, .pixel
  );

  // points behind the camera come out as all-zero coordinates
  `DPP_ASSERT(a_behind_zero, clk, rst, pixel_valid && pixel.behind_camera |-> (pixel.pixel_u == '0) && (pixel.pixel_v == '0) && !pixel.saturated)
  // pipeline is empty right after reset
  `DPP_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !pixel_valid)

endmodule

>>> design/dpp_front.sv
// ----------------------------------------------------------------------------
// dpp_front
// Register file and input classification: camera select, depth check.
// ----------------------------------------------------------------------------
module dpp_front import dpp_pkg::*; #(
  parameter int NUM_CAMERAS = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  point_valid,
  output logic                  point_stall,
  input  point_beat_t           point,
  input  queue_status_t         q_status,
  output logic                  push,
  output work_t                 work,
  output cam_cfg_t              cfg_view [CAM_SLOTS]
);

  cam_cfg_t cfg_reg [NUM_CAMERAS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CAMERAS; c++) cfg_reg[c] <= '0;
    end else if (cfg_write) begin
      for (int c = 0; c < NUM_CAMERAS; c++) begin
        if (int'(cfg_index[CFG_CAM_BIT]) == c) begin
          unique case (cfg_reg_t'(cfg_index[1:0]))
            REG_FOCAL: begin
              cfg_reg[c].fx <= cfg_data[63:32];
              cfg_reg[c].fy <= cfg_data[31:0];
            end
            REG_CENTER: begin
              cfg_reg[c].cx <= cfg_data[63:32];
              cfg_reg[c].cy <= cfg_data[31:0];
            end
            REG_RADIAL: begin
              cfg_reg[c].k1 <= cfg_data[63:32];
              cfg_reg[c].k2 <= cfg_data[31:0];
            end
            REG_TANGENTIAL: begin
              cfg_reg[c].p1 <= cfg_data[63:32];
              cfg_reg[c].p2 <= cfg_data[31:0];
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  for (genvar c = 0; c < CAM_SLOTS; c++) begin : g_view
    if (c < NUM_CAMERAS) begin : g_used
      assign cfg_view[c] = cfg_reg[c];
    end else begin : g_unused
      assign cfg_view[c] = '0;
    end
  end

  assign point_stall = q_status.full;
  assign push        = point_valid && !q_status.full;

  always_comb begin
    // out-of-range camera falls back to camera 0
    work.cam    = (int'(point.camera) < NUM_CAMERAS) ? point.camera : 1'b0;
    work.behind = (point.point_z <= 32'sd0);
    work.x      = point.point_x;
    work.y      = point.point_y;
    work.z      = point.point_z;
  end

endmodule

>>> design/dpp_queue.sv
// ----------------------------------------------------------------------------
// dpp_queue
// Short FIFO between the front and the back, head read combinationally.
// ----------------------------------------------------------------------------
module dpp_queue import dpp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  work_t         wdata,
  input  logic          pop,
  output work_t         rdata,
  output queue_status_t status
);

  work_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  assign rdata            = mem[rd_ptr];
  assign status.full      = (count == (Q_PTR_W+1)'(Q_DEPTH));
  assign status.not_empty = (count != '0);

endmodule

>>> design/dpp_div.sv
// ----------------------------------------------------------------------------
// dpp_div
// Pipelined restoring divider: |num| * 2^30 / den, two quotient bits a stage.
// ----------------------------------------------------------------------------
module dpp_div import dpp_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic [W_Q-1:0]     quo,
  output logic               ovf,
  output logic               neg
);

  localparam int NSTG = W_Q / 2;
  localparam int RW   = 31;

  logic [RW-1:0]  rem_s  [NSTG+1];
  logic [RW-1:0]  den_s  [NSTG+1];
  logic [W_Q-1:0] quo_s  [NSTG+1];
  logic [3:0]     feed_s [NSTG+1];
  logic           ovf_s  [NSTG+1];
  logic           neg_s  [NSTG+1];

  logic [31:0] num_u;
  logic [31:0] mag;

  // returns {quotient bit, remainder}
  function automatic logic [RW:0] div_step(input logic [RW-1:0] r, input logic b,
                                           input logic [RW-1:0] d);
    logic [RW:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) return {1'b1, RW'(t - {1'b0, d})};
    else return {1'b0, t[RW-1:0]};
  endfunction

  assign num_u = num;
  assign mag   = num_u[31] ? (~num_u + 32'd1) : num_u;

  // quotient of more than 34 bits means far beyond the clamp
  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0]  <= RW'(mag >> 4);
      den_s[0]  <= den[RW-1:0];
      quo_s[0]  <= '0;
      feed_s[0] <= mag[3:0];
      ovf_s[0]  <= ((mag >> 4) >= {1'b0, den[RW-1:0]});
      neg_s[0]  <= num_u[31];
    end
  end

  for (genvar k = 1; k <= NSTG; k++) begin : g_stage
    logic [RW:0] s1;
    logic [RW:0] s2;
    assign s1 = div_step(rem_s[k-1], feed_s[k-1][3], den_s[k-1]);
    assign s2 = div_step(s1[RW-1:0], feed_s[k-1][2], den_s[k-1]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k]  <= s2[RW-1:0];
        quo_s[k]  <= {quo_s[k-1][W_Q-3:0], s1[RW], s2[RW]};
        feed_s[k] <= {feed_s[k-1][1:0], 2'b00};
        den_s[k]  <= den_s[k-1];
        ovf_s[k]  <= ovf_s[k-1];
        neg_s[k]  <= neg_s[k-1];
      end
    end
  end

  assign quo = quo_s[NSTG];
  assign ovf = ovf_s[NSTG];
  assign neg = neg_s[NSTG];

endmodule

>>> design/dpp_mul.sv
// ----------------------------------------------------------------------------
// dpp_mul
// Two-stage signed multiplier, b split in halves, result floor(a*b / 2^30).
// ----------------------------------------------------------------------------
module dpp_mul import dpp_pkg::*; #(
  parameter int WA = 32,
  parameter int WB = 32,
  parameter int WO = 34
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [WA-1:0] a,
  input  logic signed [WB-1:0] b,
  output logic signed [WO-1:0] p
);

  localparam int H  = WB / 2;
  localparam int WP = WA + WB;

  logic signed [H:0]         lo_s;
  logic signed [WB-H-1:0]    hi_s;
  logic signed [WA+H:0]      part_lo;
  logic signed [WA+WB-H-1:0] part_hi;
  logic signed [WP-1:0]      prod;

  assign lo_s = {1'b0, b[H-1:0]};
  assign hi_s = b[WB-1:H];

  always_ff @(posedge clk) begin
    if (en) begin
      part_lo <= a * lo_s;
      part_hi <= a * hi_s;
    end
  end

  assign prod = (WP'(part_hi) <<< H) + WP'(part_lo);

  // arithmetic part-select above the fraction is the floor shift
  always_ff @(posedge clk) begin
    if (en) p <= prod[FRAC +: WO];
  end

endmodule

>>> design/dpp_back.sv
// ----------------------------------------------------------------------------
// dpp_back
// Projection pipeline: divide, clamp, distortion terms, pixel mapping.
// ----------------------------------------------------------------------------
module dpp_back import dpp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cam_cfg_t      cfg_view [CAM_SLOTS],
  input  queue_status_t q_status,
  input  work_t         head,
  output logic          pop,
  output logic          pixel_valid,
  input  logic          pixel_stall,
  output pixel_beat_t   pixel
);

  // tag index of each stage's registered result
  localparam int T_DIV   = W_Q / 2;
  localparam int T_CLAMP = T_DIV + 1;
  localparam int T_M1    = T_CLAMP + MUL_LAT;
  localparam int T_A     = T_M1 + 1;
  localparam int T_M2    = T_A + MUL_LAT;
  localparam int T_M3    = T_M2 + MUL_LAT;
  localparam int T_B     = T_M3 + 1;
  localparam int T_M4    = T_B + MUL_LAT;
  localparam int T_C     = T_M4 + 1;
  localparam int T_M5    = T_C + MUL_LAT;
  localparam int T_OUT   = T_M5 + 1;
  localparam int XN_DLY  = T_B - T_CLAMP;
  localparam int K_DLY   = T_M3 - T_M2;
  localparam int TAN_DLY = T_M4 - T_B;

  localparam logic signed [W_F-1:0] ONE_F = {{(W_F-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};
  localparam logic signed [W_U-1:0] PIX_MAX = W_U'(32'sh7FFF_FFFF);
  localparam logic signed [W_U-1:0] PIX_MIN = W_U'(signed'(32'h8000_0000));

  logic en;
  logic vld [T_OUT+1];
  tag_t tag [T_OUT];

  // divider outputs
  logic [W_Q-1:0] qx, qy;
  logic           ovx, ovy, ngx, ngy;

  logic [W_N:0] cl_x, cl_y;
  logic signed [W_N-1:0] xn_r, yn_r;
  logic signed [W_N-1:0] xn_d [XN_DLY];
  logic signed [W_N-1:0] yn_d [XN_DLY];

  logic signed [W_SQ-1:0] xx, yy, xy;
  logic signed [W_R2-1:0] r2_c, r2_a;
  logic signed [W_T-1:0]  tx_a, ty_a;
  logic signed [W_SQ-1:0] xy_a;

  logic signed [W_R4-1:0]   r4;
  logic signed [W_K1R2-1:0] k1r2;
  logic signed [W_PXY-1:0]  p1xy, p2xy;
  logic signed [W_PT-1:0]   p2tx, p1ty;
  logic signed [W_K2R4-1:0] k2r4;

  logic signed [W_K1R2-1:0] k1r2_d [K_DLY];
  logic signed [W_PXY-1:0]  p1xy_d [K_DLY];
  logic signed [W_PXY-1:0]  p2xy_d [K_DLY];
  logic signed [W_PT-1:0]   p2tx_d [K_DLY];
  logic signed [W_PT-1:0]   p1ty_d [K_DLY];

  logic signed [W_F-1:0]   f_b;
  logic signed [W_TAN-1:0] tanx_b, tany_b;
  logic signed [W_TAN-1:0] tanx_d [TAN_DLY];
  logic signed [W_TAN-1:0] tany_d [TAN_DLY];

  logic signed [W_XF-1:0]  xnf, ynf;
  logic signed [W_X1-1:0]  x1_c, y1_c;
  logic signed [32:0]      fx_s, fy_s;
  logic signed [W_PIX-1:0] fxx1, fyy1;
  logic signed [W_U-1:0]   u_c, v_c;
  logic [32:0]             cu, cv;

  pixel_beat_t res;

  // {sat, value}: clamp magnitude to 8.0, then apply the sign
  function automatic logic [W_N:0] norm_clamp(input logic [W_Q-1:0] q, input logic ov,
                                              input logic ng);
    logic [W_Q-1:0] m;
    logic           s;
    logic [W_N-1:0] v;
    s = ov || (q > NORM_LIM);
    m = s ? NORM_LIM : q;
    v = ng ? (~W_N'(m) + 1'b1) : W_N'(m);
    return {s, v};
  endfunction

  // {sat, pixel}
  function automatic logic [32:0] pix_clamp(input logic signed [W_U-1:0] v);
    priority if (v > PIX_MAX) return {1'b1, 32'h7FFF_FFFF};
    else if (v < PIX_MIN) return {1'b1, 32'h8000_0000};
    else return {1'b0, v[31:0]};
  endfunction

  assign en          = !(vld[T_OUT] && pixel_stall);
  assign pop         = en && q_status.not_empty;
  assign pixel_valid = vld[T_OUT];
  assign pixel       = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= T_OUT; j++) vld[j] <= 1'b0;
    end else if (en) begin
      vld[0] <= pop;
      for (int j = 1; j <= T_OUT; j++) vld[j] <= vld[j-1];
    end
  end

  // the clamp stage picks up the normalized saturation flag
  always_ff @(posedge clk) begin
    if (en) begin
      tag[0] <= '{cam: head.cam, behind: head.behind, sat: 1'b0};
      for (int j = 1; j < T_OUT; j++) begin
        if (j == T_CLAMP) begin
          tag[j] <= '{cam: tag[j-1].cam, behind: tag[j-1].behind,
                      sat: cl_x[W_N] | cl_y[W_N]};
        end else begin
          tag[j] <= tag[j-1];
        end
      end
    end
  end

  dpp_div u_div_x (.clk, .en, .num(head.x), .den(head.z), .quo(qx), .ovf(ovx), .neg(ngx));
  dpp_div u_div_y (.clk, .en, .num(head.y), .den(head.z), .quo(qy), .ovf(ovy), .neg(ngy));

  assign cl_x = norm_clamp(qx, ovx, ngx);
  assign cl_y = norm_clamp(qy, ovy, ngy);

  always_ff @(posedge clk) begin
    if (en) begin
      xn_r    <= cl_x[W_N-1:0];
      yn_r    <= cl_y[W_N-1:0];
      xn_d[0] <= xn_r;
      yn_d[0] <= yn_r;
      for (int j = 1; j < XN_DLY; j++) begin
        xn_d[j] <= xn_d[j-1];
        yn_d[j] <= yn_d[j-1];
      end
    end
  end

  dpp_mul #(.WA(W_N), .WB(W_N), .WO(W_SQ)) u_xx (.clk, .en, .a(xn_r), .b(xn_r), .p(xx));
  dpp_mul #(.WA(W_N), .WB(W_N), .WO(W_SQ)) u_yy (.clk, .en, .a(yn_r), .b(yn_r), .p(yy));
  dpp_mul #(.WA(W_N), .WB(W_N), .WO(W_SQ)) u_xy (.clk, .en, .a(xn_r), .b(yn_r), .p(xy));

  assign r2_c = W_R2'(xx) + W_R2'(yy);

  always_ff @(posedge clk) begin
    if (en) begin
      r2_a <= r2_c;
      tx_a <= W_T'(r2_c) + (W_T'(xx) <<< 1);
      ty_a <= W_T'(r2_c) + (W_T'(yy) <<< 1);
      xy_a <= xy;
    end
  end

  dpp_mul #(.WA(W_R2), .WB(W_R2), .WO(W_R4)) u_r4 (
    .clk, .en, .a(r2_a), .b(r2_a), .p(r4));
  dpp_mul #(.WA(32), .WB(W_R2), .WO(W_K1R2)) u_k1r2 (
    .clk, .en, .a(cfg_view[tag[T_A].cam].k1), .b(r2_a), .p(k1r2));
  dpp_mul #(.WA(32), .WB(W_SQ), .WO(W_PXY)) u_p1xy (
    .clk, .en, .a(cfg_view[tag[T_A].cam].p1), .b(xy_a), .p(p1xy));
  dpp_mul #(.WA(32), .WB(W_SQ), .WO(W_PXY)) u_p2xy (
    .clk, .en, .a(cfg_view[tag[T_A].cam].p2), .b(xy_a), .p(p2xy));
  dpp_mul #(.WA(32), .WB(W_T), .WO(W_PT)) u_p2tx (
    .clk, .en, .a(cfg_view[tag[T_A].cam].p2), .b(tx_a), .p(p2tx));
  dpp_mul #(.WA(32), .WB(W_T), .WO(W_PT)) u_p1ty (
    .clk, .en, .a(cfg_view[tag[T_A].cam].p1), .b(ty_a), .p(p1ty));

  dpp_mul #(.WA(32), .WB(W_R4), .WO(W_K2R4)) u_k2r4 (
    .clk, .en, .a(cfg_view[tag[T_M2].cam].k2), .b(r4), .p(k2r4));

  // hold first-order terms while k2*r4 finishes
  always_ff @(posedge clk) begin
    if (en) begin
      k1r2_d[0] <= k1r2;
      p1xy_d[0] <= p1xy;
      p2xy_d[0] <= p2xy;
      p2tx_d[0] <= p2tx;
      p1ty_d[0] <= p1ty;
      for (int j = 1; j < K_DLY; j++) begin
        k1r2_d[j] <= k1r2_d[j-1];
        p1xy_d[j] <= p1xy_d[j-1];
        p2xy_d[j] <= p2xy_d[j-1];
        p2tx_d[j] <= p2tx_d[j-1];
        p1ty_d[j] <= p1ty_d[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_b    <= ONE_F + W_F'(k1r2_d[K_DLY-1]) + W_F'(k2r4);
      tanx_b <= (W_TAN'(p1xy_d[K_DLY-1]) <<< 1) + W_TAN'(p2tx_d[K_DLY-1]);
      tany_b <= W_TAN'(p1ty_d[K_DLY-1]) + (W_TAN'(p2xy_d[K_DLY-1]) <<< 1);
      tanx_d[0] <= tanx_b;
      tany_d[0] <= tany_b;
      for (int j = 1; j < TAN_DLY; j++) begin
        tanx_d[j] <= tanx_d[j-1];
        tany_d[j] <= tany_d[j-1];
      end
    end
  end

  dpp_mul #(.WA(W_N), .WB(W_F), .WO(W_XF)) u_xnf (
    .clk, .en, .a(xn_d[XN_DLY-1]), .b(f_b), .p(xnf));
  dpp_mul #(.WA(W_N), .WB(W_F), .WO(W_XF)) u_ynf (
    .clk, .en, .a(yn_d[XN_DLY-1]), .b(f_b), .p(ynf));

  always_ff @(posedge clk) begin
    if (en) begin
      x1_c <= W_X1'(xnf) + W_X1'(tanx_d[TAN_DLY-1]);
      y1_c <= W_X1'(ynf) + W_X1'(tany_d[TAN_DLY-1]);
    end
  end

  // focal lengths are unsigned
  assign fx_s = {1'b0, cfg_view[tag[T_C].cam].fx};
  assign fy_s = {1'b0, cfg_view[tag[T_C].cam].fy};

  dpp_mul #(.WA(33), .WB(W_X1), .WO(W_PIX)) u_fx (.clk, .en, .a(fx_s), .b(x1_c), .p(fxx1));
  dpp_mul #(.WA(33), .WB(W_X1), .WO(W_PIX)) u_fy (.clk, .en, .a(fy_s), .b(y1_c), .p(fyy1));

  assign u_c = W_U'(fxx1) + W_U'(cfg_view[tag[T_M5].cam].cx);
  assign v_c = W_U'(fyy1) + W_U'(cfg_view[tag[T_M5].cam].cy);
  assign cu  = pix_clamp(u_c);
  assign cv  = pix_clamp(v_c);

  always_ff @(posedge clk) begin
    if (en) begin
      if (tag[T_M5].behind) begin
        res <= '{pixel_u: '0, pixel_v: '0, behind_camera: 1'b1, saturated: 1'b0};
      end else begin
        res.pixel_u       <= cu[31:0];
        res.pixel_v       <= cv[31:0];
        res.behind_camera <= 1'b0;
        res.saturated     <= tag[T_M5].sat | cu[32] | cv[32];
      end
    end
  end

endmodule

>>> verif/tb_distorted_pinhole_projection_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Projection block testbench
// Feeds camera-frame points through the block under several camera settings
// and idle patterns. Each accepted point is projected by a local fixed-point
// predictor, and every pixel beat is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_distorted_pinhole_projection_top;
  import dpp_pkg::*;

  localparam longint Q30_ONE  = 64'sd1 << 30;
  localparam longint NORM_MAX = 64'sd8 << 30;
  localparam int     LIMIT    = 400000;
  localparam int     HOLD_LEN = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        point_valid = 1'b0;
  logic        point_stall;
  point_beat_t point = '0;
  logic        pixel_valid;
  logic        pixel_stall = 1'b0;
  pixel_beat_t pixel;

  // local copy of the camera registers, [camera][register]
  logic [63:0] cam_regs [2][4];

  point_beat_t pending_points[$];
  pixel_beat_t expected_pixels[$];

  int send_idle = 0;      // percent of cycles the sender idles
  int recv_idle = 0;      // percent of cycles the receiver stalls
  bit hold_request = 0;   // ask receiver for one long hold-off
  int hold_left = 0;
  bit hold_done = 0;
  int errors = 0;
  int checked = 0;
  int behind_seen = 0;
  int sat_seen = 0;
  int cycles = 0;

  distorted_pinhole_projection_top i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .point_valid(point_valid), .point_stall(point_stall), .point(point),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // floor(a*b / 2^30), saturated to 64 bits
  function automatic longint mul_floor_q30(longint a, longint b);
    logic signed [127:0] sa, sb, pr;
    sa = a;
    sb = b;
    pr = (sa * sb) >>> 30;
    if (pr > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (pr < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return pr[63:0];
  endfunction

  function automatic longint clamp_unit(longint v, ref bit sat);
    if (v > NORM_MAX) begin sat = 1; return NORM_MAX; end
    if (v < -NORM_MAX) begin sat = 1; return -NORM_MAX; end
    return v;
  endfunction

  function automatic logic [31:0] clamp_pix(longint v, ref bit sat);
    if (v > 64'sd2147483647) begin sat = 1; v = 64'sd2147483647; end
    if (v < -64'sd2147483648) begin sat = 1; v = -64'sd2147483648; end
    return v[31:0];
  endfunction

  function automatic pixel_beat_t project_point(point_beat_t p);
    pixel_beat_t r;
    bit sat;
    longint fx, fy, cx, cy, k1, k2, p1, p2;
    longint x, y, z, xn, yn, xx, yy, xy, r2, r4, f, x1, y1;
    logic [63:0] foc, cen, rad, tan;
    r = '0;
    sat = 0;
    x = p.point_x;
    y = p.point_y;
    z = p.point_z;
    if (z <= 0) begin
      r.behind_camera = 1'b1;
      return r;
    end
    foc = cam_regs[p.camera][REG_FOCAL];
    cen = cam_regs[p.camera][REG_CENTER];
    rad = cam_regs[p.camera][REG_RADIAL];
    tan = cam_regs[p.camera][REG_TANGENTIAL];
    fx = {32'd0, foc[63:32]};
    fy = {32'd0, foc[31:0]};
    cx = $signed(cen[63:32]);
    cy = $signed(cen[31:0]);
    k1 = $signed(rad[63:32]);
    k2 = $signed(rad[31:0]);
    p1 = $signed(tan[63:32]);
    p2 = $signed(tan[31:0]);
    xn = clamp_unit((x * Q30_ONE) / z, sat);   // truncates toward zero
    yn = clamp_unit((y * Q30_ONE) / z, sat);
    xx = mul_floor_q30(xn, xn);
    yy = mul_floor_q30(yn, yn);
    xy = mul_floor_q30(xn, yn);
    r2 = xx + yy;
    r4 = mul_floor_q30(r2, r2);
    f = Q30_ONE + mul_floor_q30(k1, r2) + mul_floor_q30(k2, r4);
    x1 = mul_floor_q30(xn, f) + 2 * mul_floor_q30(p1, xy) + mul_floor_q30(p2, r2 + 2 * xx);
    y1 = mul_floor_q30(yn, f) + mul_floor_q30(p1, r2 + 2 * yy) + 2 * mul_floor_q30(p2, xy);
    r.pixel_u = clamp_pix(mul_floor_q30(fx, x1) + cx, sat);
    r.pixel_v = clamp_pix(mul_floor_q30(fy, y1) + cy, sat);
    r.saturated = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %0s: got %0d want %0d (beat %0d)", what, got, want, checked);
    errors++;
  endtask

  // append one point to the pending list
  function automatic void add_point(point_beat_t p);
    pending_points.insert(pending_points.size(), p);
  endfunction

  // sender: hold payload while stalled, prediction taken on the accepting edge
  always @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else begin
      if (point_valid && !point_stall)
        expected_pixels.insert(expected_pixels.size(), project_point(point));
      if (!point_valid || !point_stall) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= send_idle) begin
          point <= pending_points.pop_front();
          point_valid <= 1'b1;
        end else begin
          point_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall plus one long hold-off counted here
  always @(posedge clk) begin
    if (rst) begin
      pixel_stall <= 1'b0;
    end else if (hold_request && !hold_done && hold_left == 0) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
      pixel_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pixel_stall <= (hold_left > 1);
    end else begin
      pixel_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // monitor: compare each pixel beat with the oldest prediction
  always @(posedge clk) begin
    pixel_beat_t want;
    if (!rst && pixel_valid && !pixel_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (pixel.pixel_u !== want.pixel_u) report_mismatch("pixel_u", pixel.pixel_u, want.pixel_u);
        if (pixel.pixel_v !== want.pixel_v) report_mismatch("pixel_v", pixel.pixel_v, want.pixel_v);
        if (pixel.behind_camera !== want.behind_camera)
          report_mismatch("behind_camera", pixel.behind_camera, want.behind_camera);
        if (pixel.saturated !== want.saturated)
          report_mismatch("saturated", pixel.saturated, want.saturated);
        behind_seen += want.behind_camera;
        sat_seen += want.saturated;
      end
      checked++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(int idx, logic [63:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx[2:0];
    cfg_data <= data;
    cam_regs[idx >> 2][idx & 3] = data;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // wait for every queued point to go and every pixel to return
  task automatic drain();
    while (pending_points.size() > 0 || point_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic point_beat_t rand_point();
    point_beat_t p;
    int kind;
    kind = $urandom_range(9);
    p.camera = $urandom_range(1);
    p.point_x = $urandom;
    p.point_y = $urandom;
    p.point_z = $urandom;
    if (kind == 1) begin
      p.point_z = -$signed({1'b0, 31'($urandom)});  // zero or behind
    end else if (kind >= 2) begin
      // well-formed: depth in front, lateral offsets mostly inside the view
      p.point_z = $urandom_range(32'h7FFF_FFFF, 1) >> $urandom_range(12);
      if (p.point_z == 0) p.point_z = 1;
      p.point_x = $signed(p.point_x) >>> $urandom_range(14, 2);
      p.point_y = $signed(p.point_y) >>> $urandom_range(14, 2);
    end
    return p;
  endfunction

  function automatic point_beat_t mk(bit cam, int x, int y, int z);
    point_beat_t p;
    p.camera = cam;
    p.point_x = x;
    p.point_y = y;
    p.point_z = z;
    return p;
  endfunction

  task automatic config_camera(int cam, int setting);
    logic [63:0] v [4];
    case (setting)
      0: begin  // typical lens, modest distortion
        v[0] = {32'd500 << 16, 32'd480 << 16};
        v[1] = {32'd320 << 16, 32'd240 << 16};
        v[2] = {32'sh0100_0000 * (cam ? -1 : 1), 32'sh0040_0000};
        v[3] = {32'sh0001_0000, -32'sh0002_0000};
      end
      1: begin  // max focal, extreme center, most negative radial distortion
        v[0] = '1;
        v[1] = {32'h7FFF_FFFF, 32'h8000_0000};
        v[2] = {32'h8000_0000, 32'h8000_0000};
        v[3] = {32'h7FFF_FFFF, 32'h8000_0000};
      end
      2: begin  // most positive radial distortion, zero focal
        v[0] = '0;
        v[1] = {32'h8000_0000, 32'h7FFF_FFFF};
        v[2] = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
        v[3] = {32'h8000_0000, 32'h7FFF_FFFF};
      end
      default: begin
        v[0] = {$urandom, $urandom} >> $urandom_range(24);
        v[1] = {$urandom, $urandom};
        v[2] = {$urandom, $urandom};
        v[3] = {$urandom, $urandom};
      end
    endcase
    for (int r = 0; r < 4; r++) write_reg(cam * 4 + r, v[r]);
  endtask

  initial begin
    for (int c = 0; c < 2; c++)
      for (int r = 0; r < 4; r++) cam_regs[c][r] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed beats against reset registers first, then a typical lens
    for (int s = 0; s < 2; s++) begin
      if (s == 1) begin
        config_camera(0, 0);
        config_camera(1, 0);
      end
      add_point(mk(0, 32'h7FFF_FFFF, 32'h8000_0000, 1));
      add_point(mk(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      add_point(mk(0, 1 << 16, -(1 << 16), 0));
      add_point(mk(1, 1 << 16, 1 << 16, -1));
      add_point(mk(0, 0, 0, 32'h8000_0000));
      add_point(mk(1, 0, 0, 1 << 16));
      add_point(mk(0, 8 << 16, -(8 << 16), 1 << 16));
      add_point(mk(1, (8 << 16) + 1, 3 << 16, 1 << 16));
      add_point(mk(0, -1, 1, 32'h7FFF_FFFF));
      add_point(mk(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
      add_point(mk(0, 12345, -6789, 1 << 20));
      drain();
    end

    // random phases: each changes both cameras and the idle pattern
    for (int ph = 0; ph < 9; ph++) begin
      config_camera(0, ph % 4);
      config_camera(1, (ph + 1) % 4);
      case (ph % 3)
        0: begin send_idle = 8;  recv_idle = 81; end
        1: begin send_idle = 81; recv_idle = 8;  end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (ph == 2) hold_request = 1;  // back-pressure long enough to fill the queue
      for (int i = 0; i < 100; i++) add_point(rand_point());
      drain();
    end

    $display("checked %0d pixel beats over 11 camera settings, %0d behind camera, %0d saturated",
             checked, behind_seen, sat_seen);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d beats still expected", errors, expected_pixels.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/dpp_pkg.sv
design/dpp_front.sv
design/dpp_queue.sv
design/dpp_div.sv
design/dpp_mul.sv
design/dpp_back.sv
design/distorted_pinhole_projection_top.sv
verif/tb_distorted_pinhole_projection_top.sv
